// ===== hdl/fasm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame alive monitor package
// Types, register indexes and helper functions shared by the monitor files.
// ----------------------------------------------------------------------------
package fasm_pkg;

    typedef enum logic [2:0] {
        STATUS_IDLE         = 3'd0,
        STATUS_NO_NEW_FRAME = 3'd1,
        STATUS_INVALID      = 3'd2,
        STATUS_ALIVE_STALE  = 3'd3,
        STATUS_ACCEPTED     = 3'd4
    } status_t;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAFE_STATE_MAX      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_STATE_MAX     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIMEOUT_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_FRAME_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIVE_STALE_LIMIT   = 3'd4;

    localparam logic [3:0] SAFE_DECODE_MAX = 4'd3;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;
    localparam logic [3:0] STATE_MAX_RESET = 4'd3;
    localparam logic [7:0] LIMIT_RESET     = 8'd3;

    typedef struct packed {
        logic        frame_valid;
        logic [31:0] frame_seq;
        logic [7:0]  payload_byte0;
        logic [7:0]  payload_byte1;
        logic [7:0]  payload_byte2;
    } frame_item_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] safe_state;
        logic [3:0] speed_state;
        logic       brake_on;
        logic [3:0] event_state;
        logic       ack_pressed;
        logic       message_valid_bit;
        logic [3:0] alive_count;
        logic       fail_safe;
        logic       ack_trigger;
    } result_item_t;

    typedef struct packed {
        logic [3:0] safe_state_max;
        logic [3:0] speed_state_max;
        logic [7:0] frame_timeout_limit;
        logic [7:0] invalid_frame_limit;
        logic [7:0] alive_stale_limit;
    } monitor_cfg_t;

    typedef struct packed {
        logic [31:0] last_sequence;
        logic [7:0]  no_frame_count;
        logic [7:0]  invalid_count;
        logic        alive_seen;
        logic [3:0]  previous_alive;
        logic [7:0]  stale_count;
        logic        ack_seen;
        logic [3:0]  previous_ack;
    } monitor_state_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] value);
        return (value == COUNT_MAX) ? value : value + 8'd1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fasm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame alive monitor channels
// Valid/ready channels for frame items, result items and register writes.
// ----------------------------------------------------------------------------
interface fasm_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic [31:0] frame_seq;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;

    modport source (
        output valid, frame_valid, frame_seq, payload_byte0, payload_byte1, payload_byte2,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, frame_seq, payload_byte0, payload_byte1, payload_byte2,
        output ready
    );
endinterface

interface fasm_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] safe_state;
    logic [3:0] speed_state;
    logic       brake_on;
    logic [3:0] event_state;
    logic       ack_pressed;
    logic       message_valid_bit;
    logic [3:0] alive_count;
    logic       fail_safe;
    logic       ack_trigger;

    modport source (
        output valid, status, safe_state, speed_state, brake_on, event_state,
               ack_pressed, message_valid_bit, alive_count, fail_safe, ack_trigger,
        input  ready
    );
    modport sink (
        input  valid, status, safe_state, speed_state, brake_on, event_state,
               ack_pressed, message_valid_bit, alive_count, fail_safe, ack_trigger,
        output ready
    );
endinterface

interface fasm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/fasm_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame alive monitor check
// Evaluates one frame item against the monitor state and registers.
// ----------------------------------------------------------------------------
module fasm_check
    import fasm_pkg::*;
(
    input  frame_item_t    item,
    input  monitor_cfg_t   cfg_regs,
    input  monitor_state_t state,
    output monitor_state_t state_next,
    output result_item_t   result
);

    logic [3:0] raw_safe;
    logic [3:0] raw_speed;
    logic [3:0] alive;
    logic [3:0] ack;
    logic       reserved;
    logic       invalid;
    logic [7:0] no_frame_inc;
    logic [7:0] invalid_inc;
    logic [7:0] stale_new;

    assign raw_safe  = item.payload_byte0[3:0];
    assign raw_speed = item.payload_byte0[7:4];
    assign reserved  = item.payload_byte1[7];
    assign alive     = item.payload_byte2[3:0];
    assign ack       = item.payload_byte2[7:4];
    assign invalid   = reserved || (raw_safe > cfg_regs.safe_state_max)
                       || (raw_speed > cfg_regs.speed_state_max);

    assign no_frame_inc = sat_inc(state.no_frame_count);
    assign invalid_inc  = sat_inc(state.invalid_count);

    always_comb
    begin
        if (!state.alive_seen) begin
            stale_new = 8'd0;
        end else if (alive == state.previous_alive) begin
            stale_new = sat_inc(state.stale_count);
        end else begin
            stale_new = 8'd0;
        end
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.status = STATUS_IDLE;
        if (item.frame_valid) begin
            if (item.frame_seq == state.last_sequence) begin
                state_next.no_frame_count = no_frame_inc;
                result.status    = STATUS_NO_NEW_FRAME;
                result.fail_safe = (no_frame_inc >= cfg_regs.frame_timeout_limit);
            end else begin
                state_next.last_sequence  = item.frame_seq;
                state_next.no_frame_count = 8'd0;
                result.safe_state        = (raw_safe <= SAFE_DECODE_MAX) ? raw_safe : 4'd0;
                result.speed_state       = raw_speed;
                result.brake_on          = item.payload_byte1[0];
                result.event_state       = item.payload_byte1[4:1];
                result.ack_pressed       = item.payload_byte1[5];
                result.message_valid_bit = item.payload_byte1[6];
                result.alive_count       = alive;
                if (invalid) begin
                    state_next.invalid_count = invalid_inc;
                    result.status    = STATUS_INVALID;
                    result.fail_safe = (invalid_inc >= cfg_regs.invalid_frame_limit);
                end else begin
                    state_next.invalid_count  = 8'd0;
                    state_next.alive_seen     = 1'b1;
                    state_next.stale_count    = stale_new;
                    state_next.previous_alive = alive;
                    if (stale_new >= cfg_regs.alive_stale_limit) begin
                        result.status    = STATUS_ALIVE_STALE;
                        result.fail_safe = 1'b1;
                    end else begin
                        result.status           = STATUS_ACCEPTED;
                        result.ack_trigger      = state.ack_seen && (ack != state.previous_ack);
                        state_next.ack_seen     = 1'b1;
                        state_next.previous_ack = ack;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/frame_alive_sequence_monitor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame alive sequence monitor
// Checks sequence, content and alive count of periodically sampled frames.
// ----------------------------------------------------------------------------
// The monitor accepts one frame item per clock cycle while a second result
// register is empty and delivers each result item from a result register;
// the second one holds one more item while the result side stalls. Register
// writes are always accepted and must be made while no items are in flight.
module frame_alive_sequence_monitor_unit
    import fasm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    fasm_frame_if.sink    frame,
    fasm_result_if.source result,
    fasm_cfg_if.sink      cfg
);

    monitor_cfg_t   cfg_reg;
    monitor_cfg_t   cfg_next;
    monitor_state_t state_reg;
    monitor_state_t state_next;
    monitor_state_t check_state_next;
    frame_item_t    item;
    result_item_t   check_result;
    result_item_t   out_reg;
    result_item_t   out_next;
    result_item_t   skid_reg;
    result_item_t   skid_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    logic           accept;
    logic           take;

    assign item.frame_valid   = frame.frame_valid;
    assign item.frame_seq     = frame.frame_seq;
    assign item.payload_byte0 = frame.payload_byte0;
    assign item.payload_byte1 = frame.payload_byte1;
    assign item.payload_byte2 = frame.payload_byte2;

    assign frame.ready = !skid_valid_reg;
    assign cfg.ready   = 1'b1;
    assign accept      = frame.valid && frame.ready;
    assign take        = result.valid && result.ready;

    fasm_check u_check (
        .item       (item),
        .cfg_regs   (cfg_reg),
        .state      (state_reg),
        .state_next (check_state_next),
        .result     (check_result)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            unique case (cfg.index)
                CFG_SAFE_STATE_MAX:      cfg_next.safe_state_max      = cfg.data[3:0];
                CFG_SPEED_STATE_MAX:     cfg_next.speed_state_max     = cfg.data[3:0];
                CFG_FRAME_TIMEOUT_LIMIT: cfg_next.frame_timeout_limit = cfg.data;
                CFG_INVALID_FRAME_LIMIT: cfg_next.invalid_frame_limit = cfg.data;
                CFG_ALIVE_STALE_LIMIT:   cfg_next.alive_stale_limit   = cfg.data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    assign state_next = accept ? check_state_next : state_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = check_result;
                out_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = check_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.safe_state_max      <= STATE_MAX_RESET;
            cfg_reg.speed_state_max     <= STATE_MAX_RESET;
            cfg_reg.frame_timeout_limit <= LIMIT_RESET;
            cfg_reg.invalid_frame_limit <= LIMIT_RESET;
            cfg_reg.alive_stale_limit   <= LIMIT_RESET;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.status            = out_reg.status;
    assign result.safe_state        = out_reg.safe_state;
    assign result.speed_state       = out_reg.speed_state;
    assign result.brake_on          = out_reg.brake_on;
    assign result.event_state       = out_reg.event_state;
    assign result.ack_pressed       = out_reg.ack_pressed;
    assign result.message_valid_bit = out_reg.message_valid_bit;
    assign result.alive_count       = out_reg.alive_count;
    assign result.fail_safe         = out_reg.fail_safe;
    assign result.ack_trigger       = out_reg.ack_trigger;

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("second result register holds an item while the first is empty");

    a_accepted_no_fail : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_ACCEPTED) |-> !out_reg.fail_safe)
        else $error("accepted frame reported with fail_safe set");

    a_trigger_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ack_trigger) |-> (out_reg.status == STATUS_ACCEPTED))
        else $error("ack_trigger raised on a frame that was not accepted");

    a_idle_keeps_state : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame.frame_valid) |=> $stable(state_reg))
        else $error("idle tick changed the monitor state");

    a_stale_fails : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_ALIVE_STALE) |-> out_reg.fail_safe)
        else $error("stale frame reported without fail_safe");

endmodule
`default_nettype wire
